### design/isaac_pkg.sv
// Shared types, constants and helper functions of the ISAAC generator.
`default_nettype none

package isaac_pkg;

    localparam int POOL_LOG2 = 8;
    localparam int POOL_SIZE = 1 << POOL_LOG2;

    typedef logic [POOL_LOG2-1:0] t_addr;
    typedef logic [31:0]          t_word;

    localparam t_addr HALF_OFS  = t_addr'(POOL_SIZE / 2);
    localparam t_addr BLK_STEP  = t_addr'(8);
    localparam t_addr LAST_BLK  = t_addr'(POOL_SIZE - 8);
    localparam t_addr LAST_IDX  = t_addr'(POOL_SIZE - 1);
    localparam t_word GOLDEN    = 32'h9e3779b9;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_REFILL = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUT,
        ST_SCR,
        ST_FADD,
        ST_FMIX,
        ST_FWR,
        ST_BSTART,
        ST_BATCH
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_READ,
        DP_INIT_CLR,
        DP_MIX,
        DP_FILL_ADD,
        DP_FILL_WR,
        DP_BSTART,
        DP_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [2:0]  row;
        logic        src_pool;
        logic        rd_en;
        logic        add_en;
        t_addr       addr;
        logic [1:0]  phase;
    } t_dp_cmd;

    function automatic t_word mix_shift(input logic [2:0] row, input t_word v);
        t_word r;
        case (row)
            3'd0:    r = v << 11;
            3'd1:    r = v >> 2;
            3'd2:    r = v << 8;
            3'd3:    r = v >> 16;
            3'd4:    r = v << 10;
            3'd5:    r = v >> 4;
            3'd6:    r = v << 8;
            default: r = v >> 9;
        endcase
        return r;
    endfunction

    function automatic t_word step_shift(input logic [1:0] ph, input t_word v);
        t_word r;
        case (ph)
            2'd0:    r = v << 13;
            2'd1:    r = v >> 6;
            2'd2:    r = v << 2;
            default: r = v >> 16;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/isaac_dp.sv
// Datapath of the ISAAC generator: pool and result memories, mixing registers and step logic.
`default_nettype none

module isaac_dp import isaac_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  wire  [7:0]  i_word_index,
    input  t_word       i_seed_word,
    output t_word       o_random_word,
    output logic [7:0]  o_read_index
);

    t_word r_pool  [POOL_SIZE];
    t_word r_store [POOL_SIZE];

    t_word r_pool_q0, r_pool_q1, r_store_q;
    t_word r_s [8];
    t_word r_a, r_b, r_cnt, r_x, r_y;
    logic  r_fwd;
    t_addr r_idx;

    logic  pool_re0, pool_re1, pool_we, store_re, store_we;
    t_addr pool_ra0, pool_ra1, pool_wa, store_ra, store_wa;
    t_word pool_wd, store_wd;

    t_addr idx;
    t_word y_sum, b_new, src_q;
    t_addr y_idx;

    assign idx   = t_addr'(i_word_index);
    assign y_sum = r_pool_q0 + r_a + r_b;
    assign y_idx = y_sum[POOL_LOG2+2 +: POOL_LOG2];
    assign b_new = (r_fwd ? r_y : r_pool_q1) + r_x;
    assign src_q = i_cmd.src_pool ? r_pool_q0 : r_store_q;

    always_comb begin
        pool_re0 = 1'b0;
        pool_re1 = 1'b0;
        pool_we  = 1'b0;
        store_re = 1'b0;
        store_we = 1'b0;
        pool_ra0 = i_cmd.addr;
        pool_ra1 = i_cmd.addr + HALF_OFS;
        pool_wa  = i_cmd.addr;
        pool_wd  = r_s[0];
        store_ra = i_cmd.addr;
        store_wa = i_cmd.addr;
        store_wd = b_new;
        case (i_cmd.op)
            DP_LOAD: begin
                store_we = 1'b1;
                store_wa = idx;
                store_wd = i_seed_word;
            end
            DP_READ: begin
                store_re = 1'b1;
                store_ra = idx;
            end
            DP_FILL_ADD: begin
                if (i_cmd.rd_en) begin
                    pool_re0 = i_cmd.src_pool;
                    store_re = !i_cmd.src_pool;
                end
            end
            DP_FILL_WR: begin
                pool_we = 1'b1;
            end
            DP_STEP: begin
                case (i_cmd.phase)
                    2'd0: begin
                        pool_re0 = 1'b1;
                        pool_re1 = 1'b1;
                    end
                    2'd1: begin
                        pool_re0 = 1'b1;
                        pool_ra0 = r_pool_q0[2 +: POOL_LOG2];
                    end
                    2'd2: begin
                        pool_we  = 1'b1;
                        pool_wd  = y_sum;
                        pool_re1 = 1'b1;
                        pool_ra1 = y_idx;
                    end
                    default: begin
                        store_we = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool[pool_wa] <= pool_wd;
        end
        if (pool_re0) begin
            r_pool_q0 <= r_pool[pool_ra0];
        end
        if (pool_re1) begin
            r_pool_q1 <= r_pool[pool_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_wa] <= store_wd;
        end
        if (store_re) begin
            r_store_q <= r_store[store_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_cnt <= '0;
        end else begin
            case (i_cmd.op)
                DP_INIT_CLR: begin
                    r_a   <= '0;
                    r_b   <= '0;
                    r_cnt <= '0;
                end
                DP_BSTART: begin
                    r_cnt <= r_cnt + 32'd1;
                    r_b   <= r_b + r_cnt + 32'd1;
                end
                DP_STEP: begin
                    if (i_cmd.phase == 2'd1) begin
                        r_a <= (r_a ^ step_shift(i_cmd.addr[1:0], r_a)) + r_pool_q1;
                    end else if (i_cmd.phase == 2'd3) begin
                        r_b <= b_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_INIT_CLR: begin
                for (int k = 0; k < 8; k++) begin
                    r_s[k] <= GOLDEN;
                end
            end
            DP_MIX: begin
                r_s[7] <= r_s[0] ^ mix_shift(i_cmd.row, r_s[1]);
                r_s[0] <= r_s[1] + r_s[2];
                r_s[1] <= r_s[2];
                r_s[2] <= r_s[3] + (r_s[0] ^ mix_shift(i_cmd.row, r_s[1]));
                for (int k = 3; k < 7; k++) begin
                    r_s[k] <= r_s[k+1];
                end
            end
            DP_FILL_ADD: begin
                if (i_cmd.add_en) begin
                    for (int k = 0; k < 7; k++) begin
                        r_s[k] <= r_s[k+1];
                    end
                    r_s[7] <= r_s[0] + src_q;
                end
            end
            DP_FILL_WR: begin
                for (int k = 0; k < 7; k++) begin
                    r_s[k] <= r_s[k+1];
                end
                r_s[7] <= r_s[0];
            end
            DP_READ: begin
                r_idx <= idx;
            end
            DP_STEP: begin
                if (i_cmd.phase == 2'd1) begin
                    r_x <= r_pool_q0;
                end else if (i_cmd.phase == 2'd2) begin
                    r_y   <= y_sum;
                    r_fwd <= (y_idx == i_cmd.addr);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_random_word = r_store_q;
    assign o_read_index  = 8'(r_idx);

endmodule

`default_nettype wire

### design/isaac_ctrl.sv
// Controller state machine of the ISAAC generator: command decode and sequencing.
`default_nettype none

module isaac_ctrl import isaac_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire  [1:0]  i_cmd,
    input  wire         i_use_seed,
    input  wire         i_m_tready,
    output logic        o_s_tready,
    output logic        o_m_tvalid,
    output t_dp_cmd     o_dp_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_row, n_row;
    logic [1:0] r_rnd, n_rnd;
    logic [3:0] r_j, n_j;
    t_addr      r_fa, n_fa;
    logic       r_pass, n_pass;
    logic       r_seeded, n_seeded;
    t_addr      r_i, n_i;
    logic [1:0] r_ph, n_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_rnd    <= '0;
            r_j      <= '0;
            r_fa     <= '0;
            r_pass   <= 1'b0;
            r_seeded <= 1'b0;
            r_i      <= '0;
            r_ph     <= '0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_rnd    <= n_rnd;
            r_j      <= n_j;
            r_fa     <= n_fa;
            r_pass   <= n_pass;
            r_seeded <= n_seeded;
            r_i      <= n_i;
            r_ph     <= n_ph;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_rnd    = r_rnd;
        n_j      = r_j;
        n_fa     = r_fa;
        n_pass   = r_pass;
        n_seeded = r_seeded;
        n_i      = r_i;
        n_ph     = r_ph;
        o_s_tready        = 1'b0;
        o_m_tvalid        = 1'b0;
        o_dp_cmd          = '0;
        o_dp_cmd.op       = DP_NOP;
        o_dp_cmd.row      = r_row;
        o_dp_cmd.src_pool = r_pass;
        o_dp_cmd.addr     = r_fa + t_addr'(r_j[2:0]);
        o_dp_cmd.phase    = r_ph;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    case (t_cmd'(i_cmd))
                        CMD_LOAD: begin
                            o_dp_cmd.op = DP_LOAD;
                        end
                        CMD_INIT: begin
                            o_dp_cmd.op = DP_INIT_CLR;
                            n_seeded    = i_use_seed;
                            n_row       = '0;
                            n_rnd       = '0;
                            n_state     = ST_SCR;
                        end
                        CMD_REFILL: begin
                            n_state = ST_BSTART;
                        end
                        default: begin
                            o_dp_cmd.op = DP_READ;
                            n_state     = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCR: begin
                o_dp_cmd.op = DP_MIX;
                n_row       = r_row + 3'd1;
                if (r_row == 3'd7) begin
                    n_rnd = r_rnd + 2'd1;
                    if (r_rnd == 2'd3) begin
                        n_fa    = '0;
                        n_pass  = 1'b0;
                        n_j     = '0;
                        n_state = r_seeded ? ST_FADD : ST_FMIX;
                    end
                end
            end
            ST_FADD: begin
                o_dp_cmd.op     = DP_FILL_ADD;
                o_dp_cmd.rd_en  = !r_j[3];
                o_dp_cmd.add_en = (r_j != 4'd0);
                n_j             = r_j + 4'd1;
                if (r_j == 4'd8) begin
                    n_j     = '0;
                    n_row   = '0;
                    n_state = ST_FMIX;
                end
            end
            ST_FMIX: begin
                o_dp_cmd.op = DP_MIX;
                n_row       = r_row + 3'd1;
                if (r_row == 3'd7) begin
                    n_j     = '0;
                    n_state = ST_FWR;
                end
            end
            ST_FWR: begin
                o_dp_cmd.op = DP_FILL_WR;
                n_j         = r_j + 4'd1;
                if (r_j == 4'd7) begin
                    n_j  = '0;
                    n_fa = r_fa + BLK_STEP;
                    if (r_fa == LAST_BLK) begin
                        if (r_seeded && !r_pass) begin
                            n_pass  = 1'b1;
                            n_state = ST_FADD;
                        end else begin
                            n_state = ST_BSTART;
                        end
                    end else begin
                        n_state = r_seeded ? ST_FADD : ST_FMIX;
                    end
                end
            end
            ST_BSTART: begin
                o_dp_cmd.op = DP_BSTART;
                n_i         = '0;
                n_ph        = '0;
                n_state     = ST_BATCH;
            end
            ST_BATCH: begin
                o_dp_cmd.op   = DP_STEP;
                o_dp_cmd.addr = r_i;
                n_ph          = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    n_i = r_i + t_addr'(1);
                    if (r_i == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_s_tvalid && i_cmd == CMD_READ) |=> o_m_tvalid)
        else $error("Accepted read did not present a result word.");

    a_bstart_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BSTART) |=> (r_state == ST_BATCH && r_i == '0 && r_ph == 2'd0))
        else $error("Batch did not start at index zero.");

    a_batch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BATCH && r_ph != 2'd3) |=> (r_state == ST_BATCH && $stable(r_i)))
        else $error("Batch step left before its last phase.");

    a_fill_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FADD || r_state == ST_FWR) |-> (r_fa[2:0] == 3'd0))
        else $error("Fill block base is not aligned.");

endmodule

`default_nettype wire

### design/isaac_random_generator.sv
// Top level of the ISAAC random generator: stream ports, controller and datapath.
//
// Channel   Direction  Words carried
// s (in)    slave      one command word: load, init, refill or read
// m (out)   master     one result word for each read command
//
// Load completes on acceptance; read presents its word in the cycle after acceptance.
// Refill steps through every pool index: it reads and rewrites the pool and stores a result.
// Init clears and scrambles the state, fills the pool (two passes when seeded), then refills.
// Only one command is in work at a time; o_s_tready is low until it completes.
// Reset is synchronous and active low; the memories hold no defined contents until written.
`default_nettype none

module isaac_random_generator import isaac_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // word_index[7:0], seed_word[39:8], use_seed[40], zero pad
    input  wire  [1:0]  i_s_tuser,   // cmd[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata    // random_word[31:0], read_index[39:32]
);

    t_dp_cmd    dp_cmd;
    t_word      random_word;
    logic [7:0] read_index;

    isaac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_use_seed (i_s_tdata[40]),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_dp_cmd   (dp_cmd)
    );

    isaac_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_word_index  (i_s_tdata[7:0]),
        .i_seed_word   (i_s_tdata[39:8]),
        .o_random_word (random_word),
        .o_read_index  (read_index)
    );

    assign o_m_tdata = {read_index, random_word};

endmodule

`default_nettype wire
